// ===== hw/rtl/bst_pkg.sv =====
// bst_pkg: shared constants, codes, beat structs and the sequencer state type
// for the branch slot table. Used by branch_slot_table and bst_ram users.
// No dependencies.
package bst_pkg;

    // table geometry
    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SCAN_W  = IDX_W + 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int ID_W   = 32;
    localparam int TICK_W = 64;
    localparam int LIVE_W = 9;

    // operation codes
    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_SWITCH = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;
    localparam logic [1:0] FUNC_DELETE = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_PROTECTED = 2'd3;

    // id reported by a refused create
    localparam logic [ID_W-1:0] ID_NONE = '1;

    typedef struct packed {
        logic [1:0]        func;
        logic [ID_W-1:0]   target_id;
        logic [ID_W-1:0]   parent_id;
        logic [TICK_W-1:0] tick_value;
        logic [TICK_W-1:0] hash_value;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   result_id;
        logic [ID_W-1:0]   current_id;
        logic [LIVE_W-1:0] live_count;
        logic [ID_W-1:0]   entry_parent;
        logic [TICK_W-1:0] entry_tick;
        logic [TICK_W-1:0] entry_hash;
    } rsp_t;

    // one slot word as held in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   parent;
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] hash;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

// ===== hw/rtl/bst_ram.sv =====
// bst_ram: generic single-write, single-read memory with registered read data.
// Self-contained; width and depth set by parameters.
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/branch_slot_table.sv =====
// branch_slot_table: top level, sequencer that scans the slot table one slot a cycle.
// Depends on bst_pkg and bst_ram.
//
// Usage:
// - request channel req_valid / req_stall / req carries one operation beat:
//   create, switch, find or delete. rsp_valid / rsp_stall / rsp returns one
//   beat per request with status, ids, live count and the found entry fields.
// - one request is worked on at a time; req_stall is high from the accept
//   until the result has been moved into the output register.
// - create walks the valid bits from slot 0 up to the first free slot and
//   writes it in that same cycle. A refused create (full table) and a
//   delete of id 0 skip the scan and go straight to the response state.
// - switch, find and delete stream the slot memory through its read port,
//   one slot per cycle, and compare each slot word once the registered read
//   port returns it; the scan ends at a hit or after the last slot.
// - throughput is therefore set by the slot scan, one slot per cycle; no new
//   request is taken until the last result has reached the output register.
// - after reset only slot 0 is live (id 0, all fields zero), the current
//   branch is 0, the next id is 1 and the live count is 1.
// - while rsp_stall holds the output beat, the next request is still
//   accepted and worked on; its result waits until the output is free.
module branch_slot_table
    import bst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // sequencer and table state
    state_t              state_reg, state_next;
    req_t                op_reg, op_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    cmp_reg, cmp_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic                main_wr_reg, main_wr_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [ID_W-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // staged result of the running operation
    logic [1:0]          res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [ID_W-1:0]     res_parent_reg, res_parent_next;
    logic [TICK_W-1:0]   res_tick_reg, res_tick_next;
    logic [TICK_W-1:0]   res_hash_reg, res_hash_next;

    // output register
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // slot memory port
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    slot_t               ram_wr_data;
    logic [IDX_W-1:0]    ram_rd_addr;
    slot_t               ram_rd_data;

    // scan helpers
    logic [IDX_W-1:0]    scan_idx;
    logic                table_full;
    logic                free_here;
    logic                issue_rd;
    slot_t               cmp_word;
    logic                hit;
    logic                last_cmp;
    logic                rsp_free;
    logic                is_create;

    bst_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // shared compare and scan terms
    always_comb
    begin
        scan_idx    = scan_reg[IDX_W-1:0];
        table_full  = count_reg >= CNT_W'(ENTRIES);
        free_here   = !valid_reg[scan_idx];
        issue_rd    = scan_reg < SCAN_W'(ENTRIES);
        // slot 0 holds the reset main entry until it is first rewritten
        cmp_word    = (cmp_reg == '0 && !main_wr_reg) ? '0 : ram_rd_data;
        hit         = pend_reg && valid_reg[cmp_reg] && (cmp_word.id == op_reg.target_id);
        last_cmp    = cmp_reg == IDX_W'(ENTRIES - 1);
        rsp_free    = !rsp_valid_reg || !rsp_stall;
        is_create   = op_reg.func == FUNC_CREATE;
        ram_rd_addr = scan_idx;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if ((req.func == FUNC_CREATE && table_full) ||
                        (req.func == FUNC_DELETE && req.target_id == '0))
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (is_create)
                begin
                    if (free_here)
                    begin
                        state_next = ST_RESP;
                    end
                end
                else if (hit || (pend_reg && last_cmp))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs of the sequencer
    always_comb
    begin
        op_next         = op_reg;
        scan_next       = scan_reg;
        pend_next       = 1'b0;
        cmp_next        = cmp_reg;
        valid_next      = valid_reg;
        main_wr_next    = main_wr_reg;
        next_id_next    = next_id_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_parent_next = res_parent_reg;
        res_tick_next   = res_tick_reg;
        res_hash_next   = res_hash_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = scan_idx;
        ram_wr_data     = '{id: next_id_reg, parent: op_reg.parent_id,
                            tick: op_reg.tick_value, hash: op_reg.hash_value};

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = req;
                    scan_next       = '0;
                    res_status_next = STATUS_OK;
                    res_id_next     = req.target_id;
                    res_parent_next = '0;
                    res_tick_next   = '0;
                    res_hash_next   = '0;
                    if (req.func == FUNC_CREATE && table_full)
                    begin
                        res_status_next = STATUS_FULL;
                        res_id_next     = ID_NONE;
                    end
                    else if (req.func == FUNC_DELETE && req.target_id == '0)
                    begin
                        res_status_next = STATUS_PROTECTED;
                    end
                end
            end
            ST_SCAN:
            begin
                if (is_create)
                begin
                    // fill the first free slot in the cycle it is seen
                    if (free_here)
                    begin
                        ram_wr_en            = 1'b1;
                        valid_next[scan_idx] = 1'b1;
                        if (scan_idx == '0)
                        begin
                            main_wr_next = 1'b1;
                        end
                        res_id_next  = next_id_reg;
                        next_id_next = next_id_reg + 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                else
                begin
                    // stream reads, compare each word in the cycle after its read is issued
                    if (issue_rd)
                    begin
                        pend_next = 1'b1;
                        cmp_next  = scan_idx;
                        scan_next = scan_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        pend_next = 1'b0;
                        case (op_reg.func)
                            FUNC_SWITCH:
                            begin
                                cur_next = op_reg.target_id;
                            end
                            FUNC_FIND:
                            begin
                                res_parent_next = cmp_word.parent;
                                res_tick_next   = cmp_word.tick;
                                res_hash_next   = cmp_word.hash;
                            end
                            FUNC_DELETE:
                            begin
                                valid_next[cmp_reg] = 1'b0;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                                if (cur_reg == op_reg.target_id)
                                begin
                                    cur_next = '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (pend_reg && last_cmp)
                    begin
                        pend_next       = 1'b0;
                        res_status_next = STATUS_NOT_FOUND;
                    end
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next.status       = res_status_reg;
                    rsp_next.result_id    = res_id_reg;
                    rsp_next.current_id   = cur_reg;
                    rsp_next.live_count   = LIVE_W'(count_reg);
                    rsp_next.entry_parent = res_parent_reg;
                    rsp_next.entry_tick   = res_tick_reg;
                    rsp_next.entry_hash   = res_hash_reg;
                    rsp_valid_next        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            valid_reg     <= ENTRIES'(1);
            main_wr_reg   <= 1'b0;
            next_id_reg   <= ID_W'(1);
            cur_reg       <= '0;
            count_reg     <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            main_wr_reg   <= main_wr_next;
            next_id_reg   <= next_id_next;
            cur_reg       <= cur_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        scan_reg       <= scan_next;
        cmp_reg        <= cmp_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_parent_reg <= res_parent_next;
        res_tick_reg   <= res_tick_next;
        res_hash_reg   <= res_hash_next;
        rsp_reg        <= rsp_next;
    end

    // channel outputs
    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== bench/tb_branch_slot_table.sv =====
`timescale 1ns / 1ps
// tb_branch_slot_table: self-checking bench, with a queue-fed request driver, a result
// monitor and a table predictor. Depends on bst_pkg and branch_slot_table (the DUT).
module tb_branch_slot_table
    import bst_pkg::*;
();

    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // operations waiting to be offered, and results owed by the block
    req_t ops_to_send[$];
    rsp_t answers_due[$];

    // idle rates in percent, set per phase by the stimulus process
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_go = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    rsp_t want_rsp;

    // predicted table contents
    bit                live_bit  [ENTRIES];
    logic [ID_W-1:0]   id_of     [ENTRIES];
    logic [ID_W-1:0]   parent_of [ENTRIES];
    logic [TICK_W-1:0] tick_of   [ENTRIES];
    logic [TICK_W-1:0] hash_of   [ENTRIES];
    logic [ID_W-1:0]   id_counter;
    logic [ID_W-1:0]   cur_branch;
    int                live_total;

    branch_slot_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // applies one operation to the predicted table and returns its answer
    function automatic rsp_t table_predict(input req_t op);
        rsp_t ans;
        int   i;
        int   hit;
        int   free_slot;
        ans = '0;
        ans.status = STATUS_OK;
        ans.result_id = op.target_id;
        // lowest live slot holding the id, and lowest free slot
        hit = -1;
        free_slot = -1;
        for (i = ENTRIES - 1; i >= 0; i--)
        begin
            if (live_bit[i] && id_of[i] == op.target_id)
                hit = i;
            if (!live_bit[i])
                free_slot = i;
        end
        case (op.func)
            FUNC_CREATE:
            begin
                if (live_total >= ENTRIES || free_slot < 0)
                begin
                    ans.status = STATUS_FULL;
                    ans.result_id = ID_NONE;
                end
                else
                begin
                    ans.result_id = id_counter;
                    live_bit[free_slot] = 1'b1;
                    id_of[free_slot] = id_counter;
                    parent_of[free_slot] = op.parent_id;
                    tick_of[free_slot] = op.tick_value;
                    hash_of[free_slot] = op.hash_value;
                    id_counter = id_counter + 1'b1;
                    live_total++;
                end
            end
            FUNC_SWITCH:
            begin
                if (hit < 0)
                    ans.status = STATUS_NOT_FOUND;
                else
                    cur_branch = op.target_id;
            end
            FUNC_FIND:
            begin
                if (hit < 0)
                    ans.status = STATUS_NOT_FOUND;
                else
                begin
                    ans.entry_parent = parent_of[hit];
                    ans.entry_tick = tick_of[hit];
                    ans.entry_hash = hash_of[hit];
                end
            end
            default:
            begin
                if (op.target_id == '0)
                    ans.status = STATUS_PROTECTED;
                else if (hit < 0)
                    ans.status = STATUS_NOT_FOUND;
                else
                begin
                    live_bit[hit] = 1'b0;
                    if (live_total > 0)
                        live_total--;
                    if (cur_branch == op.target_id)
                        cur_branch = '0;
                end
            end
        endcase
        ans.current_id = cur_branch;
        ans.live_count = LIVE_W'(live_total);
        return ans;
    endfunction

    // request driver: payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                answers_due.push_back(table_predict(req));
            if (!req_valid || !req_stall)
            begin
                if (ops_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= ops_to_send.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result side stall, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // result monitor: each beat against the oldest owed answer
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
                report_mismatch($sformatf("result beat with no request owed: %p", rsp));
            else
            begin
                want_rsp = answers_due.pop_front();
                if (rsp.status !== want_rsp.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp.status, want_rsp.status));
                if (rsp.result_id !== want_rsp.result_id)
                    report_mismatch($sformatf("result_id %h, want %h",
                                              rsp.result_id, want_rsp.result_id));
                if (rsp.current_id !== want_rsp.current_id)
                    report_mismatch($sformatf("current_id %h, want %h",
                                              rsp.current_id, want_rsp.current_id));
                if (rsp.live_count !== want_rsp.live_count)
                    report_mismatch($sformatf("live_count %0d, want %0d",
                                              rsp.live_count, want_rsp.live_count));
                if (rsp.entry_parent !== want_rsp.entry_parent)
                    report_mismatch($sformatf("entry_parent %h, want %h",
                                              rsp.entry_parent, want_rsp.entry_parent));
                if (rsp.entry_tick !== want_rsp.entry_tick)
                    report_mismatch($sformatf("entry_tick %h, want %h",
                                              rsp.entry_tick, want_rsp.entry_tick));
                if (rsp.entry_hash !== want_rsp.entry_hash)
                    report_mismatch($sformatf("entry_hash %h, want %h",
                                              rsp.entry_hash, want_rsp.entry_hash));
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_op(input logic [1:0] func, input logic [ID_W-1:0] target,
                           input logic [ID_W-1:0] parent, input logic [TICK_W-1:0] tick,
                           input logic [TICK_W-1:0] hash);
        req_t op;
        op.func = func;
        op.target_id = target;
        op.parent_id = parent;
        op.tick_value = tick;
        op.hash_value = hash;
        while (ops_to_send.size() >= 2)
            @(negedge clk);
        ops_to_send.push_back(op);
    endtask

    task automatic wait_drained();
        while (ops_to_send.size() != 0 || req_valid || answers_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [ID_W-1:0] pick_live_id();
        int i;
        int tries;
        for (tries = 0; tries < 4000; tries++)
        begin
            i = $urandom_range(0, ENTRIES - 1);
            if (live_bit[i])
                return id_of[i];
        end
        return '0;
    endfunction

    // mostly live ids, with main, noise, recent ids and the all-ones id
    function automatic logic [ID_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return pick_live_id();
        else if (r < 75)
            return '0;
        else if (r < 85)
            return $urandom;
        else if (r < 95)
            return id_counter - ID_W'($urandom_range(0, 3));
        return ID_NONE;
    endfunction

    task automatic push_random_op();
        int r;
        logic [1:0] func;
        r = $urandom_range(0, 99);
        if (r < 35)
            func = FUNC_CREATE;
        else if (r < 50)
            func = FUNC_SWITCH;
        else if (r < 75)
            func = FUNC_FIND;
        else
            func = FUNC_DELETE;
        push_op(func, pick_target(),
                ($urandom_range(0, 1) != 0) ? pick_live_id() : ID_W'($urandom),
                {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // stimulus: directed checks, then three idle phases of random traffic
    initial
    begin
        int i;
        int n;
        logic [ID_W-1:0] doomed[$];
        for (i = 0; i < ENTRIES; i++)
        begin
            live_bit[i] = 1'b0;
            id_of[i] = '0;
            parent_of[i] = '0;
            tick_of[i] = '0;
            hash_of[i] = '0;
        end
        live_bit[0] = 1'b1;
        id_counter = 1;
        cur_branch = '0;
        live_total = 1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        send_idle_pct = 25;
        recv_idle_pct = 47;

        // main entry, main protected, field extremes, freed slot reuse
        push_op(FUNC_FIND, '0, '0, '0, '0);
        push_op(FUNC_SWITCH, '0, '0, '0, '0);
        push_op(FUNC_DELETE, '0, '1, '1, '1);
        push_op(FUNC_CREATE, '1, '0, '1, '1);
        push_op(FUNC_CREATE, 32'h5555_aaaa, '1, '0, 64'h5555_5555_aaaa_aaaa);
        push_op(FUNC_FIND, 1, '0, '0, '0);
        push_op(FUNC_FIND, 2, '1, '1, '1);
        push_op(FUNC_SWITCH, 2, '0, '0, '0);
        push_op(FUNC_DELETE, 2, '0, '0, '0);
        push_op(FUNC_FIND, 2, '0, '0, '0);
        push_op(FUNC_SWITCH, 2, '0, '0, '0);
        push_op(FUNC_DELETE, 2, '0, '0, '0);
        push_op(FUNC_SWITCH, ID_NONE, '0, '0, '0);
        push_op(FUNC_FIND, ID_NONE, '0, '0, '0);
        push_op(FUNC_DELETE, ID_NONE, '0, '0, '0);
        push_op(FUNC_CREATE, '0, 1, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
        push_op(FUNC_FIND, 3, '0, '0, '0);
        push_op(FUNC_SWITCH, 1, '0, '0, '0);
        push_op(FUNC_FIND, 0, '0, '0, '0);
        push_op(FUNC_DELETE, 1, '0, '0, '0);
        push_op(FUNC_SWITCH, 3, '0, '0, '0);

        // fill the table to the top, then a few refused creates
        wait_drained();
        n = ENTRIES - live_total + 6;
        for (i = 0; i < n; i++)
        begin
            if (i % 8 == 7)
                push_op(FUNC_FIND, pick_live_id(), '0, '0, '0);
            push_op(FUNC_CREATE, $urandom, $urandom, {$urandom, $urandom},
                    {$urandom, $urandom});
        end
        push_op(FUNC_SWITCH, pick_live_id(), '0, '0, '0);
        for (i = 0; i < 300; i++)
            push_random_op();

        // second phase: drain every branch, then random traffic
        wait_drained();
        send_idle_pct = 47;
        recv_idle_pct = 25;
        for (i = 1; i < ENTRIES; i++)
            if (live_bit[i])
                doomed.push_back(id_of[i]);
        if (doomed.size() != 0)
            push_op(FUNC_SWITCH, doomed[$urandom_range(0, doomed.size() - 1)], '0, '0, '0);
        foreach (doomed[k])
        begin
            if (k % 5 == 0)
                push_op(FUNC_FIND, doomed[k], '0, '0, '0);
            push_op(FUNC_DELETE, doomed[k], $urandom, '0, '0);
        end
        for (i = 0; i < 560; i++)
            push_random_op();

        // third phase: no idling, one long result hold-off up front
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
        for (i = 0; i < 600; i++)
            push_random_op();

        wait_drained();
        repeat (ENTRIES + 16) @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== branch_slot_table.f =====
hw/rtl/bst_pkg.sv
hw/rtl/bst_ram.sv
hw/rtl/branch_slot_table.sv
bench/tb_branch_slot_table.sv
